@@ sv/psd_pkg.sv @@
// Shared types, widths and codes for the point to segment distance pipeline.
package psd_pkg;

	localparam int CW         = 16;
	localparam int DW         = CW + 1;
	localparam int SUMW       = 2 * CW + 2;
	localparam int HW         = (SUMW + 1) / 2;
	localparam int PW         = 2 * SUMW;
	localparam int RW         = SUMW / 2;
	localparam int REMW       = RW + 3;
	localparam int DIV_PER    = 2;
	localparam int DIV_STAGES = (SUMW + DIV_PER - 1) / DIV_PER;
	localparam int SQ_PER     = 2;
	localparam int SQ_STAGES  = (RW + SQ_PER - 1) / SQ_PER;
	localparam int PIPE_LAT   = 6 + (DIV_STAGES + 1) + 1 + (SQ_STAGES + 1);
	localparam int IDXW       = 3;

	localparam logic [IDXW-1:0] REG_END_A_X = 3'd0;
	localparam logic [IDXW-1:0] REG_END_A_Y = 3'd1;
	localparam logic [IDXW-1:0] REG_END_A_Z = 3'd2;
	localparam logic [IDXW-1:0] REG_END_B_X = 3'd3;
	localparam logic [IDXW-1:0] REG_END_B_Y = 3'd4;
	localparam logic [IDXW-1:0] REG_END_B_Z = 3'd5;

	typedef enum logic [1:0] {
		CASE_A  = 2'd0,
		CASE_IN = 2'd1,
		CASE_B  = 2'd2
	} case_t;

	typedef struct packed {
		logic [CW-1:0] point_x;
		logic [CW-1:0] point_y;
		logic [CW-1:0] point_z;
	} pt_t;

	typedef struct packed {
		logic [RW-1:0] seg_distance;
		case_t         nearest_case;
	} res_t;

	typedef struct packed {
		logic [SUMW-1:0] dd;
		logic [SUMW-1:0] alt;
		case_t           kase;
	} side_t;

	typedef struct packed {
		logic [SUMW-1:0] rem;
		logic [SUMW-1:0] low;
		logic [SUMW-1:0] q;
	} div_st_t;

	typedef struct packed {
		logic [REMW-1:0] rem;
		logic [SUMW-1:0] val;
		logic [RW-1:0]   root;
	} sq_st_t;

endpackage

@@ sv/point_segment_distance_top.sv @@
// Top level of the point to segment distance pipeline.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  input    | start, busy           | point (pt_t)
//  result   | done                  | result (res_t)
//  config   | cfg_we                | cfg_index, cfg_data
//
// One item enters per clock; busy stays low. Each result appears on done
// once its item has passed the front stages, the 17 divider stages, the
// subtraction register and the 9 square root stages.
// Reset clears the valid bits and loads the endpoints with (0,0,0) and (256,0,0).
// The receiver cannot stall, so the pipeline simply advances every cycle.
module point_segment_distance_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  psd_pkg::pt_t            point,
	output logic                    done,
	output psd_pkg::res_t           result,
	input  logic                    cfg_we,
	input  logic [psd_pkg::IDXW-1:0] cfg_index,
	input  logic [psd_pkg::CW-1:0]   cfg_data
);
	import psd_pkg::*;

	logic [CW-1:0] a_q [3];
	logic [CW-1:0] b_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q[0] <= '0;
			a_q[1] <= '0;
			a_q[2] <= '0;
			b_q[0] <= CW'(256);
			b_q[1] <= '0;
			b_q[2] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_END_A_X: a_q[0] <= cfg_data;
				REG_END_A_Y: a_q[1] <= cfg_data;
				REG_END_A_Z: a_q[2] <= cfg_data;
				REG_END_B_X: b_q[0] <= cfg_data;
				REG_END_B_Y: b_q[1] <= cfg_data;
				REG_END_B_Z: b_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic [CW-1:0] p_c [3];
	assign p_c[0] = point.point_x;
	assign p_c[1] = point.point_y;
	assign p_c[2] = point.point_z;

	// Stage 1: differences P-A, B-A, P-B.
	logic          v_s1;
	logic [DW-1:0] d_s1 [3];
	logic [DW-1:0] e_s1 [3];
	logic [DW-1:0] f_s1 [3];
	// Stage 2: magnitudes and sign mismatch of the dot product terms.
	logic          v_s2;
	logic [CW-1:0] dm_s2 [3];
	logic [CW-1:0] em_s2 [3];
	logic [CW-1:0] fm_s2 [3];
	logic          ng_s2 [3];
	// Stage 3: products.
	logic            v_s3;
	logic [2*CW-1:0] dd_s3 [3];
	logic [2*CW-1:0] ee_s3 [3];
	logic [2*CW-1:0] ff_s3 [3];
	logic [2*CW-1:0] de_s3 [3];
	logic            ng_s3 [3];
	// Stage 4: sums.
	logic            v_s4;
	logic [SUMW-1:0] dd_s4, len_s4, ff_s4, pos_s4, neg_s4;
	// Stage 5: case decision.
	logic            v_s5;
	logic [SUMW-1:0] dot_s5, len_s5;
	side_t           sd_s5;
	// Stage 6: partial products of dot squared.
	logic            v_s6;
	logic [2*HW-1:0] hh_s6, hl_s6, ll_s6;
	logic [SUMW-1:0] len_s6;
	side_t           sd_s6;

	function automatic logic [CW-1:0] mag(logic [DW-1:0] v);
		logic [DW-1:0] m;
		m = v[DW-1] ? (~v + DW'(1)) : v;
		return m[CW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_axis
		always_ff @(posedge clk) begin
			d_s1[i]  <= {p_c[i][CW-1], p_c[i]} - {a_q[i][CW-1], a_q[i]};
			e_s1[i]  <= {b_q[i][CW-1], b_q[i]} - {a_q[i][CW-1], a_q[i]};
			f_s1[i]  <= {p_c[i][CW-1], p_c[i]} - {b_q[i][CW-1], b_q[i]};
			dm_s2[i] <= mag(d_s1[i]);
			em_s2[i] <= mag(e_s1[i]);
			fm_s2[i] <= mag(f_s1[i]);
			ng_s2[i] <= d_s1[i][DW-1] ^ e_s1[i][DW-1];
			dd_s3[i] <= dm_s2[i] * dm_s2[i];
			ee_s3[i] <= em_s2[i] * em_s2[i];
			ff_s3[i] <= fm_s2[i] * fm_s2[i];
			de_s3[i] <= dm_s2[i] * em_s2[i];
			ng_s3[i] <= ng_s2[i];
		end
	end

	logic [SUMW-1:0] de_x, de_y, de_z;
	assign de_x = SUMW'(de_s3[0]);
	assign de_y = SUMW'(de_s3[1]);
	assign de_z = SUMW'(de_s3[2]);

	always_ff @(posedge clk) begin
		dd_s4  <= SUMW'(dd_s3[0]) + SUMW'(dd_s3[1]) + SUMW'(dd_s3[2]);
		len_s4 <= SUMW'(ee_s3[0]) + SUMW'(ee_s3[1]) + SUMW'(ee_s3[2]);
		ff_s4  <= SUMW'(ff_s3[0]) + SUMW'(ff_s3[1]) + SUMW'(ff_s3[2]);
		pos_s4 <= (ng_s3[0] ? '0 : de_x) + (ng_s3[1] ? '0 : de_y) + (ng_s3[2] ? '0 : de_z);
		neg_s4 <= (ng_s3[0] ? de_x : '0) + (ng_s3[1] ? de_y : '0) + (ng_s3[2] ? de_z : '0);
	end

	logic [SUMW-1:0] dot_c;
	assign dot_c = pos_s4 - neg_s4;

	always_ff @(posedge clk) begin
		dot_s5   <= dot_c;
		len_s5   <= len_s4;
		sd_s5.dd <= dd_s4;
		if (len_s4 == '0 || neg_s4 > pos_s4) begin
			sd_s5.alt  <= dd_s4;
			sd_s5.kase <= CASE_A;
		end else if (dot_c > len_s4) begin
			sd_s5.alt  <= ff_s4;
			sd_s5.kase <= CASE_B;
		end else begin
			sd_s5.alt  <= dd_s4;
			sd_s5.kase <= CASE_IN;
		end
	end

	logic [HW-1:0] dot_hi, dot_lo;
	assign dot_hi = HW'(dot_s5 >> HW);
	assign dot_lo = dot_s5[HW-1:0];

	always_ff @(posedge clk) begin
		hh_s6  <= dot_hi * dot_hi;
		hl_s6  <= dot_hi * dot_lo;
		ll_s6  <= dot_lo * dot_lo;
		len_s6 <= len_s5;
		sd_s6  <= sd_s5;
	end

	logic [PW-1:0] prod_c;
	assign prod_c = (PW'(hh_s6) << (2 * HW)) + (PW'(hl_s6) << (HW + 1)) + PW'(ll_s6);

	logic            dv_valid;
	logic [SUMW-1:0] dv_quot;
	side_t           dv_side;

	psd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.dividend  (prod_c),
		.divisor   (len_s6),
		.in_side   (sd_s6),
		.out_valid (dv_valid),
		.quot      (dv_quot),
		.out_side  (dv_side)
	);

	// Squared distance: endpoint term, or perpendicular term floored at zero.
	logic            v_s7;
	logic [SUMW-1:0] d2_s7;
	case_t           cs_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		cs_s7 <= dv_side.kase;
		if (dv_side.kase != CASE_IN) begin
			d2_s7 <= dv_side.alt;
		end else if (dv_quot > dv_side.dd) begin
			d2_s7 <= '0;
		end else begin
			d2_s7 <= dv_side.dd - dv_quot;
		end
	end

	psd_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s7),
		.radicand  (d2_s7),
		.in_case   (cs_s7),
		.out_valid (done),
		.result    (result)
	);

endmodule

@@ sv/psd_div.sv @@
// Pipelined restoring divider, two quotient bits per stage.
module psd_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [psd_pkg::PW-1:0]   dividend,
	input  logic [psd_pkg::SUMW-1:0] divisor,
	input  psd_pkg::side_t         in_side,
	output logic                   out_valid,
	output logic [psd_pkg::SUMW-1:0] quot,
	output psd_pkg::side_t         out_side
);
	import psd_pkg::*;

	function automatic div_st_t div_stage(div_st_t s, logic [SUMW-1:0] den, int base);
		logic [SUMW:0] r2;
		div_st_t t;
		t = s;
		for (int i = 0; i < DIV_PER; i++) begin
			if (base + i < SUMW) begin
				r2 = {t.rem, t.low[SUMW-1]};
				t.low = {t.low[SUMW-2:0], 1'b0};
				if (r2 >= {1'b0, den}) begin
					r2 = r2 - {1'b0, den};
					t.q = {t.q[SUMW-2:0], 1'b1};
				end else begin
					t.q = {t.q[SUMW-2:0], 1'b0};
				end
				t.rem = r2[SUMW-1:0];
			end
		end
		return t;
	endfunction

	logic            v_s   [0:DIV_STAGES];
	div_st_t         st_s  [0:DIV_STAGES];
	logic [SUMW-1:0] den_s [0:DIV_STAGES];
	side_t           sd_s  [0:DIV_STAGES];

	// The quotient fits SUMW bits, so the top half of the dividend is already
	// below the divisor and starts as the partial remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		st_s[0].rem <= dividend[PW-1:SUMW];
		st_s[0].low <= dividend[SUMW-1:0];
		st_s[0].q   <= '0;
		den_s[0]    <= divisor;
		sd_s[0]     <= in_side;
	end

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			st_s[k]  <= div_stage(st_s[k-1], den_s[k-1], (k - 1) * DIV_PER);
			den_s[k] <= den_s[k-1];
			sd_s[k]  <= sd_s[k-1];
		end
	end

	assign out_valid = v_s[DIV_STAGES];
	assign quot      = st_s[DIV_STAGES].q;
	assign out_side  = sd_s[DIV_STAGES];

endmodule

@@ sv/psd_sqrt.sv @@
// Pipelined floored integer square root, two root bits per stage, one in the last.
module psd_sqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [psd_pkg::SUMW-1:0] radicand,
	input  psd_pkg::case_t         in_case,
	output logic                   out_valid,
	output psd_pkg::res_t          result
);
	import psd_pkg::*;

	function automatic sq_st_t sq_stage(sq_st_t s, int base);
		logic [REMW-1:0] r4;
		logic [REMW-1:0] trial;
		sq_st_t t;
		t = s;
		for (int i = 0; i < SQ_PER; i++) begin
			if (base + i < RW) begin
				r4 = {t.rem[REMW-3:0], t.val[SUMW-1 -: 2]};
				trial = {{(REMW - RW - 2){1'b0}}, t.root, 2'b01};
				t.val = {t.val[SUMW-3:0], 2'b00};
				if (r4 >= trial) begin
					t.rem = r4 - trial;
					t.root = {t.root[RW-2:0], 1'b1};
				end else begin
					t.rem = r4;
					t.root = {t.root[RW-2:0], 1'b0};
				end
			end
		end
		return t;
	endfunction

	logic   v_s  [0:SQ_STAGES];
	sq_st_t st_s [0:SQ_STAGES];
	case_t  cs_s [0:SQ_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		st_s[0].rem  <= '0;
		st_s[0].val  <= radicand;
		st_s[0].root <= '0;
		cs_s[0]      <= in_case;
	end

	for (genvar k = 1; k <= SQ_STAGES; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			st_s[k] <= sq_stage(st_s[k-1], (k - 1) * SQ_PER);
			cs_s[k] <= cs_s[k-1];
		end
	end

	assign out_valid           = v_s[SQ_STAGES];
	assign result.seg_distance = st_s[SQ_STAGES].root;
	assign result.nearest_case = cs_s[SQ_STAGES];

endmodule

@@ sv/psd_check.sv @@
// Port-level checker for the point to segment distance pipeline, with its bind.
module psd_check (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input psd_pkg::res_t result
);
	import psd_pkg::*;

	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("accepted item produced no result at the fixed latency");

	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without a matching accepted item");

	a_case: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.nearest_case == CASE_A || result.nearest_case == CASE_IN ||
			result.nearest_case == CASE_B))
		else $error("invalid nearest case code");

endmodule

bind point_segment_distance_top psd_check u_psd_check (.*);
